// ===== design/fpc_pkg.sv =====
// shared types, constants and tables of the first-person camera pose block
package fpc_pkg;

  typedef logic signed [24:0] ang_t;
  typedef logic signed [15:0] vec_t;

  // angles in degrees, q9.16
  localparam int DEG_HALF    = 11796480;
  localparam int DEG_TURN    = 23592960;
  localparam int DEG_QUARTER = 5898240;
  localparam int PITCH_LIMIT = 5832704;
  // half turn plus 128 turns, keeps any look sum positive before the reduction
  localparam logic signed [34:0] WRAP_BIAS = 35'sd3031695360;

  localparam int VEC_ONE     = 16384;
  localparam int CORDIC_GAIN = 652032874;
  localparam int ATAN_N      = 24;

  localparam logic [1:0] KIND_PLACE = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_LOOK  = 2'd2;

  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
  localparam logic [2:0] REG_LOOK_SENS  = 3'd1;
  localparam logic [2:0] REG_UP_X       = 3'd2;
  localparam logic [2:0] REG_UP_Y       = 3'd3;
  localparam logic [2:0] REG_UP_Z       = 3'd4;

  localparam logic [23:0] MOVE_SPEED_RST = 24'd163840;
  localparam logic [15:0] LOOK_SENS_RST  = 16'd6554;

  // atan(2^-i) in degrees q9.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  return 22'd2949120;
      5'd1:  return 22'd1740967;
      5'd2:  return 22'd919879;
      5'd3:  return 22'd466945;
      5'd4:  return 22'd234379;
      5'd5:  return 22'd117305;
      5'd6:  return 22'd58666;
      5'd7:  return 22'd29335;
      5'd8:  return 22'd14668;
      5'd9:  return 22'd7334;
      5'd10: return 22'd3667;
      5'd11: return 22'd1833;
      5'd12: return 22'd917;
      5'd13: return 22'd458;
      5'd14: return 22'd229;
      5'd15: return 22'd115;
      5'd16: return 22'd57;
      5'd17: return 22'd29;
      5'd18: return 22'd14;
      5'd19: return 22'd7;
      5'd20: return 22'd4;
      5'd21: return 22'd2;
      5'd22: return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

endpackage

// ===== design/fpc_if.sv =====
// request, result and configuration channel interfaces of the camera pose block
interface fpc_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [1:0]        direction;
  logic [15:0]       delta_time;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic              clamp_pitch;
  logic signed [31:0] place_x;
  logic signed [31:0] place_y;
  logic signed [31:0] place_z;
  logic signed [24:0] place_yaw;
  logic signed [24:0] place_pitch;

  modport source(output valid, kind, direction, delta_time, offset_x, offset_y, clamp_pitch,
                 place_x, place_y, place_z, place_yaw, place_pitch, input ready);
  modport sink(input valid, kind, direction, delta_time, offset_x, offset_y, clamp_pitch,
               place_x, place_y, place_z, place_yaw, place_pitch, output ready);
endinterface

interface fpc_pose_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [24:0] yaw_out;
  logic signed [24:0] pitch_out;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;

  modport source(output valid, pos_x, pos_y, pos_z, yaw_out, pitch_out, target_x, target_y,
                 target_z, right_x, right_y, right_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, yaw_out, pitch_out, target_x, target_y,
               target_z, right_x, right_y, right_z, output ready);
endinterface

interface fpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/fpc_cordic.sv =====
// iterative cordic giving sine and cosine in q2.14 of an angle in degrees q9.16
module fpc_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fpc_pkg::ang_t angle,
  output logic          done,
  output fpc_pkg::vec_t sin_out,
  output fpc_pkg::vec_t cos_out
);

  localparam int NSTEP = (CORDIC_STEPS < fpc_pkg::ATAN_N) ? CORDIC_STEPS : fpc_pkg::ATAN_N;
  localparam int CW = $clog2(NSTEP);

  logic signed [33:0] x, y, xn, yn, xr, yr;
  logic signed [25:0] z, zn, at, fold;
  logic [CW-1:0]      i;
  logic               busy, neg, fneg;

  always_comb begin
    at = $signed({4'b0000, fpc_pkg::atan_deg(5'(i))});
    if (z >= 0) begin
      xn = x - (y >>> i);
      yn = y + (x >>> i);
      zn = z - at;
    end else begin
      xn = x + (y >>> i);
      yn = y - (x >>> i);
      zn = z + at;
    end
    xr = xn + 34'sd32768;
    yr = yn + 34'sd32768;
    // fold the outer half turn onto the inner one
    fneg = 1'b0;
    fold = 26'(angle);
    if (angle > 25'(fpc_pkg::DEG_QUARTER)) begin
      fold = 26'(angle) - 26'(fpc_pkg::DEG_HALF);
      fneg = 1'b1;
    end else if (angle < -25'(fpc_pkg::DEG_QUARTER)) begin
      fold = 26'(angle) + 26'(fpc_pkg::DEG_HALF);
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= 34'(fpc_pkg::CORDIC_GAIN);
        y    <= '0;
        z    <= fold;
        neg  <= fneg;
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x <= xn;
        y <= yn;
        z <= zn;
        if (i == CW'(NSTEP - 1)) begin
          busy    <= 1'b0;
          done    <= 1'b1;
          cos_out <= neg ? -xr[31:16] : xr[31:16];
          sin_out <= neg ? -yr[31:16] : yr[31:16];
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/fpc_sqrt.sv =====
// bit-pair iterative integer square root of a sum of squares
module fpc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v, r, bitm, trial;
  logic        busy, ge;

  assign trial = r + bitm;
  assign ge    = v >= trial;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= 64'(radicand);
        r    <= '0;
        bitm <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          v <= v - trial;
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/fpc_div.sv =====
// restoring divider, 16 quotient bits, one bit per cycle
module fpc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [45:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic [45:0] rem;
  logic [46:0] dsh;
  logic [3:0]  cnt;
  logic        busy, ge;

  assign ge = {1'b0, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= {den, 15'b0};
        quo  <= '0;
        cnt  <= 4'd15;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) rem <= rem - dsh[45:0];
        quo <= {quo[14:0], ge};
        dsh <= dsh >> 1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/fps_camera_pose_update_top.sv =====
// top level of the first-person camera pose block: sequencer, shared multiplier, pose state
// Usage:
//   item: one request per update. kind place loads position, yaw and pitch; kind move steps
//   the position along front or right; kind look turns the camera by scaled mouse offsets.
//   pose: one result per request, the full pose after that request.
//   cfg: register writes (speed, sensitivity, world up), taken in any cycle out of reset;
//   write only while no request is in flight.
// Flow: a request is taken only in the idle state, one at a time. Place and look
//   recompute the vectors: two cordic runs, then three normalizations, each made of a
//   square root and, unless the length is zero, three divisions. All products go through
//   one 33x33 multiplier.
// Reset: position, angles and vectors clear to zero, registers take their defaults.
// Stall: the result sits in an output register; the next request is taken meanwhile and
//   its result waits in the final state until the output register is free.
module fps_camera_pose_update_top #(
  parameter int CORDIC_STEPS = 16
) (
  input logic        clk,
  input logic        rst,
  fpc_item_if.sink   item,
  fpc_pose_if.source pose,
  fpc_cfg_if.sink    cfg
);

  typedef enum logic [25:0] {
    S_IDLE      = 26'b1 << 0,
    S_WRAP      = 26'b1 << 1,
    S_WRAP_END  = 26'b1 << 2,
    S_MV_MUL    = 26'b1 << 3,
    S_MV_VEL    = 26'b1 << 4,
    S_MV_STEP   = 26'b1 << 5,
    S_MV_ADD    = 26'b1 << 6,
    S_LK_MULX   = 26'b1 << 7,
    S_LK_X      = 26'b1 << 8,
    S_LK_MULY   = 26'b1 << 9,
    S_LK_Y      = 26'b1 << 10,
    S_CS_Y_GO   = 26'b1 << 11,
    S_CS_Y_WAIT = 26'b1 << 12,
    S_CS_P_GO   = 26'b1 << 13,
    S_CS_P_WAIT = 26'b1 << 14,
    S_TV_M0     = 26'b1 << 15,
    S_TV_M1     = 26'b1 << 16,
    S_TV_M2     = 26'b1 << 17,
    S_NS_SQ     = 26'b1 << 18,
    S_SQ_GO     = 26'b1 << 19,
    S_SQ_WAIT   = 26'b1 << 20,
    S_DV_GO     = 26'b1 << 21,
    S_DV_WAIT   = 26'b1 << 22,
    S_NORM_END  = 26'b1 << 23,
    S_CROSS     = 26'b1 << 24,
    S_FIN       = 26'b1 << 25
  } state_t;

  localparam logic [1:0] NS_TARGET = 2'd0;
  localparam logic [1:0] NS_RIGHT  = 2'd1;
  localparam logic [1:0] NS_FRONT  = 2'd2;

  state_t state;

  logic [23:0]        move_speed;
  logic [15:0]        look_sens;
  fpc_pkg::vec_t      world_up [3];

  logic [31:0]        pos [3];
  fpc_pkg::ang_t      yaw, pitch;
  fpc_pkg::vec_t      tgt [3];
  fpc_pkg::vec_t      rgt [3];
  fpc_pkg::vec_t      frt [3];
  fpc_pkg::vec_t      nvec [3];

  logic signed [31:0] vec_in [3];
  logic [61:0]        sumsq;
  logic [31:0]        len;
  fpc_pkg::vec_t      sy, cy, sp, cp;
  logic [24:0]        vel;
  logic [32:0]        acc;
  logic [2:0]         cnt;
  logic               wsel;
  logic [1:0]         nsel;
  logic               ovalid;

  logic [1:0]         kind_r, dir_r;
  logic [15:0]        dt_r;
  logic signed [31:0] offx_r, offy_r;
  logic               clamp_r;
  fpc_pkg::ang_t      place_pitch_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic [1:0]         k, cr_ai, cr_bi, cr_idx;
  logic [2:0]         cr_j;
  logic signed [31:0] vin_k;
  fpc_pkg::vec_t      mv_vec, cr_a, cr_b, qv;
  logic               mv_sub;
  logic [32:0]        wsub;
  logic signed [25:0] wang_full;
  logic signed [65:0] rnd_sum, st_sum;
  logic signed [33:0] rnd16, p_sum, p_clamp;
  logic [40:0]        vel_sum;
  logic [30:0]        absv;
  logic [45:0]        dv_num;
  logic [15:0]        qc;

  logic               cs_start, cs_done, sq_start, sq_done, dv_start, dv_done;
  fpc_pkg::ang_t      cs_angle;
  fpc_pkg::vec_t      cs_sin, cs_cos;
  logic [31:0]        sq_root;
  logic [15:0]        dv_quo;

  function automatic logic [32:0] wrap_load(input logic signed [33:0] v);
    logic signed [34:0] s;
    s = 35'(v) + fpc_pkg::WRAP_BIAS;
    return s[32:0];
  endfunction

  assign item.ready = (state == S_IDLE) && !rst;
  assign cfg.ready  = !rst;
  assign pose.valid = ovalid;

  assign k = cnt[1:0];

  always_comb begin
    case (k)
      2'd0:    vin_k = vec_in[0];
      2'd1:    vin_k = vec_in[1];
      default: vin_k = vec_in[2];
    endcase
    mv_vec = (dir_r == fpc_pkg::DIR_FORWARD || dir_r == fpc_pkg::DIR_BACKWARD) ? frt[k] : rgt[k];
    mv_sub = (dir_r == fpc_pkg::DIR_BACKWARD || dir_r == fpc_pkg::DIR_LEFT);
    // cross product term pairs, two per component
    case (cnt)
      3'd0:    begin cr_ai = 2'd1; cr_bi = 2'd2; end
      3'd1:    begin cr_ai = 2'd2; cr_bi = 2'd1; end
      3'd2:    begin cr_ai = 2'd2; cr_bi = 2'd0; end
      3'd3:    begin cr_ai = 2'd0; cr_bi = 2'd2; end
      3'd4:    begin cr_ai = 2'd0; cr_bi = 2'd1; end
      3'd5:    begin cr_ai = 2'd1; cr_bi = 2'd0; end
      default: begin cr_ai = 2'd0; cr_bi = 2'd0; end
    endcase
    cr_a   = (nsel == NS_RIGHT) ? tgt[cr_ai] : world_up[cr_ai];
    cr_b   = (nsel == NS_RIGHT) ? world_up[cr_bi] : rgt[cr_bi];
    cr_j   = cnt - 3'd1;
    cr_idx = cr_j[2:1];

    wsub      = 33'(fpc_pkg::DEG_TURN) << cnt;
    wang_full = $signed({1'b0, acc[24:0]}) - 26'(fpc_pkg::DEG_HALF);
    rnd_sum   = mul_p + 66'sd32768;
    rnd16     = rnd_sum[49:16];
    st_sum    = mul_p + 66'sd8192;
    vel_sum   = mul_p[40:0] + 41'd32768;
    p_sum     = 34'(pitch) + rnd16;
    p_clamp   = p_sum;
    if (clamp_r) begin
      if (p_sum > 34'(fpc_pkg::PITCH_LIMIT)) p_clamp = 34'(fpc_pkg::PITCH_LIMIT);
      if (p_sum < -34'(fpc_pkg::PITCH_LIMIT)) p_clamp = -34'(fpc_pkg::PITCH_LIMIT);
    end

    absv   = vin_k[31] ? 31'(-vin_k) : vin_k[30:0];
    dv_num = 46'({absv, 14'b0}) + 46'(len[31:1]);
    qc     = (dv_quo > 16'(fpc_pkg::VEC_ONE)) ? 16'(fpc_pkg::VEC_ONE) : dv_quo;
    qv     = vin_k[31] ? -$signed(qc) : $signed(qc);

    cs_start = (state == S_CS_Y_GO) || (state == S_CS_P_GO);
    cs_angle = (state == S_CS_P_GO) ? pitch : yaw;
    sq_start = (state == S_SQ_GO);
    dv_start = (state == S_DV_GO) && (len != '0);
  end

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MV_MUL:  begin mul_a = 33'(move_speed); mul_b = 33'(dt_r); end
      S_MV_STEP: begin mul_a = 33'(vel); mul_b = 33'(mv_vec); end
      S_LK_MULX: begin mul_a = 33'(offx_r); mul_b = 33'(look_sens); end
      S_LK_MULY: begin mul_a = 33'(offy_r); mul_b = 33'(look_sens); end
      S_TV_M0:   begin mul_a = 33'(cy); mul_b = 33'(cp); end
      S_TV_M1:   begin mul_a = 33'(sy); mul_b = 33'(cp); end
      S_NS_SQ:   begin mul_a = 33'(vin_k); mul_b = 33'(vin_k); end
      S_CROSS:   begin mul_a = 33'(cr_a); mul_b = 33'(cr_b); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  fpc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .angle(cs_angle),
    .done(cs_done), .sin_out(cs_sin), .cos_out(cs_cos)
  );

  fpc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sumsq),
    .done(sq_done), .root(sq_root)
  );

  fpc_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(len),
    .done(dv_done), .quo(dv_quo)
  );

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state       <= S_IDLE;
      ovalid      <= 1'b0;
      move_speed  <= fpc_pkg::MOVE_SPEED_RST;
      look_sens   <= fpc_pkg::LOOK_SENS_RST;
      world_up[0] <= '0;
      world_up[1] <= 16'(fpc_pkg::VEC_ONE);
      world_up[2] <= '0;
      yaw         <= '0;
      pitch       <= '0;
      for (int n = 0; n < 3; n++) begin
        pos[n] <= '0;
        tgt[n] <= '0;
        rgt[n] <= '0;
        frt[n] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          fpc_pkg::REG_MOVE_SPEED: move_speed  <= cfg.data;
          fpc_pkg::REG_LOOK_SENS:  look_sens   <= cfg.data[15:0];
          fpc_pkg::REG_UP_X:       world_up[0] <= cfg.data[15:0];
          fpc_pkg::REG_UP_Y:       world_up[1] <= cfg.data[15:0];
          fpc_pkg::REG_UP_Z:       world_up[2] <= cfg.data[15:0];
          default: ;
        endcase
      end

      // the final state reloads the output register itself
      if (ovalid && pose.ready && state != S_FIN) ovalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            kind_r        <= item.kind;
            dir_r         <= item.direction;
            dt_r          <= item.delta_time;
            offx_r        <= item.offset_x;
            offy_r        <= item.offset_y;
            clamp_r       <= item.clamp_pitch;
            place_pitch_r <= item.place_pitch;
            unique case (item.kind)
              fpc_pkg::KIND_PLACE: begin
                pos[0] <= item.place_x;
                pos[1] <= item.place_y;
                pos[2] <= item.place_z;
                acc    <= wrap_load(34'(item.place_yaw));
                wsel   <= 1'b0;
                cnt    <= 3'd7;
                state  <= S_WRAP;
              end
              fpc_pkg::KIND_MOVE: state <= S_MV_MUL;
              fpc_pkg::KIND_LOOK: state <= S_LK_MULX;
              default:            state <= S_FIN;
            endcase
          end
        end
        // reduce modulo one turn, one shifted turn per cycle
        S_WRAP: begin
          if (acc >= wsub) acc <= acc - wsub;
          if (cnt == 3'd0) state <= S_WRAP_END;
          else cnt <= cnt - 3'd1;
        end
        S_WRAP_END: begin
          if (!wsel) begin
            yaw <= wang_full[24:0];
            if (kind_r == fpc_pkg::KIND_PLACE) begin
              acc   <= wrap_load(34'(place_pitch_r));
              wsel  <= 1'b1;
              cnt   <= 3'd7;
              state <= S_WRAP;
            end else begin
              state <= S_LK_MULY;
            end
          end else begin
            pitch <= wang_full[24:0];
            state <= S_CS_Y_GO;
          end
        end
        S_MV_MUL: state <= S_MV_VEL;
        S_MV_VEL: begin
          vel   <= vel_sum[40:16];
          cnt   <= 3'd0;
          state <= S_MV_STEP;
        end
        S_MV_STEP: state <= S_MV_ADD;
        S_MV_ADD: begin
          pos[k] <= mv_sub ? pos[k] - st_sum[45:14] : pos[k] + st_sum[45:14];
          if (k == 2'd2) begin
            state <= S_FIN;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= S_MV_STEP;
          end
        end
        S_LK_MULX: state <= S_LK_X;
        S_LK_X: begin
          acc   <= wrap_load(34'(yaw) + rnd16);
          wsel  <= 1'b0;
          cnt   <= 3'd7;
          state <= S_WRAP;
        end
        S_LK_MULY: state <= S_LK_Y;
        S_LK_Y: begin
          acc   <= wrap_load(p_clamp);
          wsel  <= 1'b1;
          cnt   <= 3'd7;
          state <= S_WRAP;
        end
        S_CS_Y_GO: state <= S_CS_Y_WAIT;
        S_CS_Y_WAIT: begin
          if (cs_done) begin
            sy    <= cs_sin;
            cy    <= cs_cos;
            state <= S_CS_P_GO;
          end
        end
        S_CS_P_GO: state <= S_CS_P_WAIT;
        S_CS_P_WAIT: begin
          if (cs_done) begin
            sp    <= cs_sin;
            cp    <= cs_cos;
            state <= S_TV_M0;
          end
        end
        S_TV_M0: state <= S_TV_M1;
        S_TV_M1: begin
          vec_in[0] <= mul_p[31:0];
          vec_in[1] <= {{2{sp[15]}}, sp, 14'b0};
          state     <= S_TV_M2;
        end
        S_TV_M2: begin
          vec_in[2] <= mul_p[31:0];
          nsel      <= NS_TARGET;
          cnt       <= 3'd0;
          state     <= S_NS_SQ;
        end
        // squares issue on counts 0..2 and land in the cycle after
        S_NS_SQ: begin
          if (cnt == 3'd0) sumsq <= '0;
          else sumsq <= sumsq + mul_p[61:0];
          if (cnt == 3'd3) state <= S_SQ_GO;
          else cnt <= cnt + 3'd1;
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_done) begin
            len   <= sq_root;
            cnt   <= 3'd0;
            state <= S_DV_GO;
          end
        end
        S_DV_GO: begin
          if (len == '0) begin
            // zero length vector normalizes to zero
            nvec[k] <= '0;
            if (k == 2'd2) state <= S_NORM_END;
            else cnt <= cnt + 3'd1;
          end else begin
            state <= S_DV_WAIT;
          end
        end
        S_DV_WAIT: begin
          if (dv_done) begin
            nvec[k] <= qv;
            if (k == 2'd2) begin
              state <= S_NORM_END;
            end else begin
              cnt   <= cnt + 3'd1;
              state <= S_DV_GO;
            end
          end
        end
        S_NORM_END: begin
          cnt <= 3'd0;
          unique case (nsel)
            NS_TARGET: begin
              for (int n = 0; n < 3; n++) tgt[n] <= nvec[n];
              nsel  <= NS_RIGHT;
              state <= S_CROSS;
            end
            NS_RIGHT: begin
              for (int n = 0; n < 3; n++) rgt[n] <= nvec[n];
              nsel  <= NS_FRONT;
              state <= S_CROSS;
            end
            default: begin
              for (int n = 0; n < 3; n++) frt[n] <= nvec[n];
              state <= S_FIN;
            end
          endcase
        end
        // even term loads a component, odd term subtracts from it
        S_CROSS: begin
          if (cnt != 3'd0) begin
            if (!cr_j[0]) vec_in[cr_idx] <= mul_p[31:0];
            else vec_in[cr_idx] <= vec_in[cr_idx] - mul_p[31:0];
          end
          if (cnt == 3'd6) begin
            cnt   <= 3'd0;
            state <= S_NS_SQ;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_FIN: begin
          if (!ovalid || pose.ready) begin
            pose.pos_x     <= pos[0];
            pose.pos_y     <= pos[1];
            pose.pos_z     <= pos[2];
            pose.yaw_out   <= yaw;
            pose.pitch_out <= pitch;
            pose.target_x  <= tgt[0];
            pose.target_y  <= tgt[1];
            pose.target_z  <= tgt[2];
            pose.right_x   <= rgt[0];
            pose.right_y   <= rgt[1];
            pose.right_z   <= rgt[2];
            ovalid         <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
